FILE: design/pfk_pkg.sv
// ----------------------------------------------------------------------------
// pfk_pkg: shared types, constants and helpers for the key square block
// Letter codes, item kinds, controller/datapath interface structs and the
// position arithmetic of the 5x5 square.
// ----------------------------------------------------------------------------
package pfk_pkg;

    // letter codes, 0 = a
    localparam logic [4:0] LET_I = 5'd8;
    localparam logic [4:0] LET_J = 5'd9;
    localparam logic [4:0] LET_X = 5'd23;

    // square geometry
    localparam int         NUM_CELLS   = 25;
    localparam int         NUM_LETTERS = 26;
    localparam logic [4:0] CELLS       = 5'd25;
    localparam logic [4:0] ALPHA       = 5'd26;
    localparam logic [4:0] LAST_LETTER = 5'd25;
    localparam logic [2:0] SIDE_LAST   = 3'd4;

    // item kinds carried on tuser
    typedef enum logic [1:0] {
        FN_CLEAR   = 2'd0,
        FN_KEY     = 2'd1,
        FN_FINISH  = 2'd2,
        FN_ENCRYPT = 2'd3
    } func_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic place_key;
        logic start_fill;
        logic fill_step;
        logic lookup;
        logic square_read;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        func_t func;
        logic  square_ready;
        logic  enc_ok;
        logic  fill_last;
        logic  out_free;
    } stat_t;

    // j shares the cell of i
    function automatic logic [4:0] fold_j(input logic [4:0] l);
        return (l == LET_J) ? LET_I : l;
    endfunction

    // row of a square position
    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        if (p < 5'd5)
            r = 3'd0;
        else if (p < 5'd10)
            r = 3'd1;
        else if (p < 5'd15)
            r = 3'd2;
        else if (p < 5'd20)
            r = 3'd3;
        else
            r = 3'd4;
        return r;
    endfunction

    // position from row and column: row * 5 + col
    function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
        logic [4:0] s;
        s = {r, 2'b00} + {2'b00, r} + {2'b00, c};
        return s;
    endfunction

    // column of a square position
    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [4:0] d;
        d = p - cell_addr(pos_row(p), 3'd0);
        return d[2:0];
    endfunction

    // next row or column with wrap
    function automatic logic [2:0] next_idx(input logic [2:0] x);
        return (x == SIDE_LAST) ? 3'd0 : x + 3'd1;
    endfunction

endpackage

FILE: design/playfair_key_square_and_encrypt.sv
// ----------------------------------------------------------------------------
// playfair_key_square_and_encrypt: Playfair key square builder and encryptor
// Builds a 5x5 key square from keyword letters and encrypts letter pairs.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | letter_a[4:0] letter_b[9:5] b_present[10] | func[1:0]
//  m_      | out | cipher_a[4:0] cipher_b[9:5]              | -
//
// Clear and key letter items finish in their accepting cycle; finish walks
// the letters a..z after it unless the square is ready; encrypt runs through
// two registered memory reads (position lookup, square lookup) and then emits.
// A result waits in the output register; the next item is still accepted,
// and an encrypt stalls in its emit state while that register is full and unread.
// Reset clears the used flags, fill count and ready flag; no clearing pass.
// ----------------------------------------------------------------------------
module playfair_key_square_and_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // letter_a[4:0], letter_b[9:5], b_present[10]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // cipher_a[4:0], cipher_b[9:5]
);
    import pfk_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pfk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfk_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

FILE: design/pfk_ctrl.sv
// ----------------------------------------------------------------------------
// pfk_ctrl: sequencing state machine
// Accepts one item at a time, runs the finish walk and the encrypt lookups.
// ----------------------------------------------------------------------------
module pfk_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  pfk_pkg::stat_t stat,
    output pfk_pkg::cmd_t  cmd
);
    import pfk_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FILL   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (stat.func)
                        FN_CLEAR:   cmd.clear = 1'b1;
                        FN_KEY:     cmd.place_key = 1'b1;
                        FN_FINISH:
                        begin
                            if (!stat.square_ready)
                            begin
                                cmd.start_fill = 1'b1;
                                state_next     = ST_FILL;
                            end
                        end
                        FN_ENCRYPT:
                        begin
                            if (stat.enc_ok)
                            begin
                                cmd.lookup = 1'b1;
                                state_next = ST_LOOKUP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                    state_next = ST_IDLE;
            end
            ST_LOOKUP:
            begin
                cmd.square_read = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: design/pfk_dp.sv
// ----------------------------------------------------------------------------
// pfk_dp: key square datapath
// Square and letter position memories, used flags, fill counter, finish
// walk counter, encrypt geometry and the output register.
// ----------------------------------------------------------------------------
module pfk_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     s_tuser,
    input  logic [15:0]    s_tdata,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [15:0]    m_tdata,
    input  pfk_pkg::cmd_t  cmd,
    output pfk_pkg::stat_t stat
);
    import pfk_pkg::*;

    // memories
    logic [4:0] key_square   [NUM_CELLS];
    logic [4:0] letter_place [NUM_LETTERS];

    // control state
    logic [NUM_LETTERS-1:0] used_reg, used_next;
    logic [4:0]             fill_reg, fill_next;
    logic                   ready_reg, ready_next;
    logic [4:0]             walk_reg, walk_next;
    logic                   out_valid_reg, out_valid_next;

    // payload registers
    logic [4:0] pa_reg, pb_reg;
    logic [4:0] ka_reg, kb_reg;
    logic [4:0] cipher_a_reg, cipher_b_reg;

    // input decode
    logic [4:0] la_in, lb_in, la_f, lb_t, lb_f;
    logic       bp_in;
    logic [4:0] pl_letter;
    logic       pl_try, pl_en;

    // geometry
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] addr_a, addr_b;

    // fold and pad the incoming pair
    always_comb
    begin
        la_in = s_tdata[4:0];
        lb_in = s_tdata[9:5];
        bp_in = s_tdata[10];
        la_f  = fold_j(la_in);
        lb_t  = bp_in ? fold_j(lb_in) : LET_X;
        lb_f  = (lb_t == la_f) ? LET_X : lb_t;
    end

    // status to the controller
    always_comb
    begin
        stat.func         = func_t'(s_tuser);
        stat.square_ready = ready_reg;
        stat.enc_ok       = ready_reg && (la_in < ALPHA) && (!bp_in || (lb_in < ALPHA));
        stat.fill_last    = (walk_reg == LAST_LETTER);
        stat.out_free     = !out_valid_reg || m_tready;
    end

    // letter placement, from a key item or the finish walk
    always_comb
    begin
        if (cmd.fill_step)
        begin
            pl_letter = walk_reg;
            pl_try    = (walk_reg != LET_J);
        end
        else
        begin
            pl_letter = la_f;
            pl_try    = cmd.place_key && !ready_reg && (la_in < ALPHA);
        end
        pl_en = pl_try && (fill_reg < CELLS) && !used_reg[pl_letter];
    end

    // control state next values
    always_comb
    begin
        used_next      = used_reg;
        fill_next      = fill_reg;
        ready_next     = ready_reg;
        walk_next      = walk_reg;
        out_valid_next = out_valid_reg;
        if (cmd.clear)
        begin
            used_next  = '0;
            fill_next  = '0;
            ready_next = 1'b0;
        end
        if (pl_en)
        begin
            used_next[pl_letter] = 1'b1;
            fill_next            = fill_reg + 5'd1;
        end
        if (cmd.start_fill)
            walk_next = '0;
        if (cmd.fill_step)
        begin
            walk_next = walk_reg + 5'd1;
            if (walk_reg == LAST_LETTER)
                ready_next = 1'b1;
        end
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            fill_reg      <= '0;
            ready_reg     <= 1'b0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            ready_reg     <= ready_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Playfair rules on the looked-up positions
    always_comb
    begin
        ra = pos_row(pa_reg);
        ca = pos_col(pa_reg);
        rb = pos_row(pb_reg);
        cb = pos_col(pb_reg);
        if (ra == rb)
        begin
            addr_a = cell_addr(ra, next_idx(ca));
            addr_b = cell_addr(rb, next_idx(cb));
        end
        else if (ca == cb)
        begin
            addr_a = cell_addr(next_idx(ra), ca);
            addr_b = cell_addr(next_idx(rb), cb);
        end
        else
        begin
            addr_a = cell_addr(ra, cb);
            addr_b = cell_addr(rb, ca);
        end
    end

    // memories with registered reads, and the output register
    always_ff @(posedge clk)
    begin
        if (pl_en)
        begin
            key_square[fill_reg]    <= pl_letter;
            letter_place[pl_letter] <= fill_reg;
        end
        if (cmd.lookup)
        begin
            pa_reg <= letter_place[la_f];
            pb_reg <= letter_place[lb_f];
        end
        if (cmd.square_read)
        begin
            ka_reg <= key_square[addr_a];
            kb_reg <= key_square[addr_b];
        end
        if (cmd.emit)
        begin
            cipher_a_reg <= ka_reg;
            cipher_b_reg <= kb_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, cipher_b_reg, cipher_a_reg};

endmodule
